### sv/atlr_pkg.sv
`default_nettype none
package atlr_pkg;

  // table size and derived widths
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // fixed field widths
  localparam int KEY_W  = 16;
  localparam int TAG_W  = 32;
  localparam int TIME_W = 32;
  localparam int USE_W  = 32;
  localparam int TOT_W  = 32;
  localparam int SLOT_W = 4;
  localparam int OCC_W  = 5;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_GET    = 2'd1,
    OP_TOUCH  = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED_FREE  = 3'd0,
    ST_ADDED_EVICT = 3'd1,
    ST_PRESENT     = 3'd2,
    ST_HIT         = 3'd3,
    ST_NOT_FOUND   = 3'd4,
    ST_REMOVED     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CMD_FILL,
    CMD_REFRESH,
    CMD_CLEAR
  } cmd_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // input item
  typedef struct packed {
    logic [1:0]        operation;
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  title_tag;
    logic [TIME_W-1:0] now;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  evicted_key;
    logic [OCC_W-1:0]  occupancy;
    logic [TOT_W-1:0]  hit_total;
    logic [TOT_W-1:0]  miss_total;
  } out_item_t;

  // query broadcast to every cell
  typedef struct packed {
    logic              by_tag;
    logic              policy;
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  title_tag;
    logic [TIME_W-1:0] now;
  } query_t;

  // write command broadcast to every cell
  typedef struct packed {
    logic             en;
    cmd_kind_t        kind;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  // running search result handed from cell to cell
  typedef struct packed {
    logic             match_found;
    logic [IDX_W-1:0] match_idx;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             vic_found;
    logic [IDX_W-1:0] vic_idx;
    logic [USE_W-1:0] vic_val;
    logic [KEY_W-1:0] vic_key;
  } carry_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage
`default_nettype wire

### sv/atlr_cell.sv
`default_nettype none
module atlr_cell
  import atlr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire query_t           query,
  input  wire cmd_t             cmd,
  input  wire carry_t           carry_in,
  output carry_t                carry_out
);

  logic              valid_r, valid_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [USE_W-1:0]  use_r, use_nxt;
  carry_t            carry_r, carry_nxt;

  logic              hit_here;
  logic [USE_W-1:0]  my_val;
  logic              take_me;

  // slot update on a write command aimed here
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    tag_nxt   = tag_r;
    time_nxt  = time_r;
    use_nxt   = use_r;
    if (cmd.en && (cmd.idx == cell_idx)) begin
      case (cmd.kind)
        CMD_FILL: begin
          valid_nxt = 1'b1;
          key_nxt   = query.key;
          tag_nxt   = query.title_tag;
          time_nxt  = query.now;
          use_nxt   = USE_W'(1);
        end
        CMD_REFRESH: begin
          time_nxt = query.now;
          use_nxt  = sat_inc32(use_r);
        end
        CMD_CLEAR: begin
          valid_nxt = 1'b0;
          time_nxt  = '0;
          use_nxt   = '0;
        end
        default: begin
          valid_nxt = valid_r;
        end
      endcase
    end
  end

  // fold this slot into the running search result
  always_comb begin
    hit_here = valid_r && (query.by_tag ? (tag_r == query.title_tag)
                                        : (key_r == query.key));
    my_val   = query.policy ? use_r : time_r;
    take_me  = !carry_in.vic_found || (my_val < carry_in.vic_val);

    carry_nxt = carry_in;
    if (!carry_in.match_found && hit_here) begin
      carry_nxt.match_found = 1'b1;
      carry_nxt.match_idx   = cell_idx;
    end
    if (!carry_in.free_found && !valid_r) begin
      carry_nxt.free_found = 1'b1;
      carry_nxt.free_idx   = cell_idx;
    end
    if (take_me) begin
      carry_nxt.vic_found = 1'b1;
      carry_nxt.vic_idx   = cell_idx;
      carry_nxt.vic_val   = my_val;
      carry_nxt.vic_key   = key_r;
    end
  end

  // control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      time_r  <= '0;
      use_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      time_r  <= time_nxt;
      use_r   <= use_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    tag_r   <= tag_nxt;
    carry_r <= carry_nxt;
  end

  assign carry_out = carry_r;

endmodule
`default_nettype wire

### sv/assoc_table_lru_lfu_replace_top.sv
`default_nettype none
// Fully associative table of ENTRIES slots built as a row of cells, one slot
// per cell. An accepted item is broadcast to every cell and a search record
// (first match, first free slot, replacement victim) moves down the row one
// cell per clock through the register in each cell. The update is then applied
// and the result register is loaded. A new item is accepted only in the idle
// state, so an item is not taken before the last one has been applied. The
// result waits in its own register, so the next item can be taken while it is
// still unread. The replacement policy register (0 oldest access time, 1 lowest
// use count) is written through the cfg port; the user must write it only while
// no item is in progress, and the block itself does not enforce this.
module assoc_table_lru_lfu_replace_top
  import atlr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_data
);

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  scan_cnt_r, scan_cnt_nxt;
  logic              policy_r;
  logic [1:0]        op_r;
  query_t            query_r;
  logic [CNT_W-1:0]  valid_count_r, valid_count_nxt;
  logic [TOT_W-1:0]  hit_r, hit_nxt;
  logic [TOT_W-1:0]  miss_r, miss_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              accept;
  logic              finish;
  cmd_t              cmd;
  carry_t            chain [ENTRIES+1];
  carry_t            res;

  // cell row
  assign chain[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    atlr_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(g)),
      .query     (query_r),
      .cmd       (cmd),
      .carry_in  (chain[g]),
      .carry_out (chain[g+1])
    );
  end

  assign res = chain[ENTRIES];

  // handshake strobes
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    case (state_r)
      S_IDLE: begin
        scan_cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + 1'b1;
        if (scan_cnt_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready = 1'b0;
    finish   = 1'b0;
    case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_SCAN:  in_ready = 1'b0;
      S_DONE:  finish   = !out_valid_r || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  // decision from the search record, counters and result
  always_comb begin
    cmd             = '0;
    cmd.kind        = CMD_FILL;
    valid_count_nxt = valid_count_r;
    hit_nxt         = hit_r;
    miss_nxt        = miss_r;
    out_data_nxt    = out_data_r;
    out_valid_nxt   = out_valid_r && !out_ready;

    if (finish) begin
      out_data_nxt.status      = ST_NOT_FOUND;
      out_data_nxt.slot        = '0;
      out_data_nxt.evicted_key = '0;
      cmd.en = 1'b0;
      if (op_r == OP_ADD) begin
        if (res.match_found) begin
          cmd.en   = 1'b1;
          cmd.kind = CMD_REFRESH;
          cmd.idx  = res.match_idx;
          out_data_nxt.status = ST_PRESENT;
        end else begin
          miss_nxt = sat_inc32(miss_r);
          cmd.en   = 1'b1;
          cmd.kind = CMD_FILL;
          if (res.free_found) begin
            cmd.idx         = res.free_idx;
            valid_count_nxt = valid_count_r + 1'b1;
            out_data_nxt.status = ST_ADDED_FREE;
          end else begin
            cmd.idx = res.vic_idx;
            out_data_nxt.evicted_key = res.vic_key;
            out_data_nxt.status      = ST_ADDED_EVICT;
          end
        end
      end else if (res.match_found) begin
        cmd.en  = 1'b1;
        cmd.idx = res.match_idx;
        if (op_r == OP_REMOVE) begin
          cmd.kind = CMD_CLEAR;
          if (valid_count_r != '0) begin
            valid_count_nxt = valid_count_r - 1'b1;
          end
          out_data_nxt.status = ST_REMOVED;
        end else begin
          cmd.kind = CMD_REFRESH;
          hit_nxt  = sat_inc32(hit_r);
          out_data_nxt.status = ST_HIT;
        end
      end
      if (cmd.en) begin
        out_data_nxt.slot = SLOT_W'(cmd.idx);
      end
      out_data_nxt.occupancy  = OCC_W'(valid_count_nxt);
      out_data_nxt.hit_total  = hit_nxt;
      out_data_nxt.miss_total = miss_nxt;
      out_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      scan_cnt_r    <= '0;
      policy_r      <= 1'b0;
      valid_count_r <= '0;
      hit_r         <= '0;
      miss_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      scan_cnt_r    <= scan_cnt_nxt;
      valid_count_r <= valid_count_nxt;
      hit_r         <= hit_nxt;
      miss_r        <= miss_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        policy_r <= cfg_data;
      end
    end
  end

  // item capture and result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      op_r              <= in_data.operation;
      query_r.by_tag    <= (in_data.operation == OP_ADD);
      query_r.policy    <= policy_r;
      query_r.key       <= in_data.key;
      query_r.title_tag <= in_data.title_tag;
      query_r.now       <= in_data.now;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
